FILE: src/gts_pkg.sv
// ----------------------------------------------------------------------------
// gts_pkg: shared types and constants for the geometric tail series sum
// Request and result structs, controller state, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int MAX_TERMS_DEFAULT = 64;
  localparam int TERM_W            = 32;
  localparam int BOUND_W           = 16;
  localparam int TOTAL_W           = 48;
  localparam int TAIL_W            = 47;
  // square of a positive 31 bit term
  localparam int SQ_W              = 2 * (TERM_W - 1);
  // one quotient bit per divider step
  localparam int DIV_STEPS         = SQ_W;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic [BOUND_W-1:0]       ratio_bound;
    logic                     last_term;
  } gts_item_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic [TAIL_W-1:0]         tail;
    logic                      tail_valid;
  } gts_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SQUARE,
    ST_DIVIDE,
    ST_FINISH
  } gts_state_t;

  typedef struct packed {
    logic accept;   // latch the incoming request
    logic step;     // fold the latched term into the series state
    logic square;   // load the divider with s*s and p-s
    logic divide;   // one restoring divider step
    logic finish;   // load the result register and clear the series
  } gts_cmd_t;

  typedef struct packed {
    logic last_term;
    logic cut_found;
    logic div_last;
  } gts_status_t;

endpackage

FILE: src/geometric_tail_series_sum.sv
// ----------------------------------------------------------------------------
// sequence: a term is taken in the idle state and then folded in by an update step
// final term with a cut point: the update, the square, the 62 step serial
//   divider and the result load; without one the divider is skipped
// request side: stalled during each update; the final term holds it until
//   its result load, and longer while the previous result is still held
// reset: synchronous, clears the series state, the sequencer and result valid
// ----------------------------------------------------------------------------
// geometric_tail_series_sum: geometric tail extrapolation of a series sum
// Sums a series of signed terms, tracks the latest point where three positive
// terms fall off geometrically, and on the last term adds the tail s*s/(p-s).
// ----------------------------------------------------------------------------
module geometric_tail_series_sum #(
  parameter int MAX_TERMS = gts_pkg::MAX_TERMS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  gts_pkg::gts_item_t   item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output gts_pkg::gts_result_t result
);

  // command and status groups between sequencer and datapath
  gts_pkg::gts_cmd_t    cmd;
  gts_pkg::gts_status_t status;

  // sequencer: idle until a request, one update step per term, and on the
  // final term the square, the division and the result load
  gts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: the running sum is saturated to the range that MAX_TERMS terms
  // can reach, the ratio test uses one 16 by 31 bit product a term, and the
  // result register parts the result channel from the request side
  gts_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // a bare sum never carries a tail
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tail_valid |-> result.tail == '0)
    else $error("tail set without a cut point");

  // every accepted request is followed by its update cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall && cmd.step)
    else $error("request not followed by an update cycle");

  // a result is loaded only when the result register is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !result_valid || !result_stall)
    else $error("result overwritten while held");

  // the divider runs only for a series with a cut point
  assert property (@(posedge clk) disable iff (rst)
    cmd.divide |-> status.cut_found)
    else $error("division without a cut point");

endmodule

FILE: src/gts_ctrl.sv
// ----------------------------------------------------------------------------
// gts_ctrl: sequencer for the geometric tail series sum
// Walks each request through its step, and on the final term through the
// square, the serial division and the result load.
// ----------------------------------------------------------------------------
module gts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  gts_pkg::gts_status_t status,
  output gts_pkg::gts_cmd_t    cmd
);

  gts_pkg::gts_state_t state, state_next;
  logic                out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gts_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      gts_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = gts_pkg::ST_STEP;
        end
      end
      gts_pkg::ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.last_term ? gts_pkg::ST_SQUARE : gts_pkg::ST_IDLE;
      end
      gts_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = status.cut_found ? gts_pkg::ST_DIVIDE : gts_pkg::ST_FINISH;
      end
      gts_pkg::ST_DIVIDE: begin
        cmd.divide = 1'b1;
        if (status.div_last) begin
          state_next = gts_pkg::ST_FINISH;
        end
      end
      gts_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = gts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/gts_dp.sv
// ----------------------------------------------------------------------------
// gts_dp: datapath of the geometric tail series sum
// Running sum, ratio test by multiplication, cut point store, restoring
// divider for the tail and the saturating result register.
// ----------------------------------------------------------------------------
module gts_dp #(
  parameter int MAX_TERMS = gts_pkg::MAX_TERMS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gts_pkg::gts_item_t   item,
  input  gts_pkg::gts_cmd_t    cmd,
  output gts_pkg::gts_status_t status,
  output gts_pkg::gts_result_t result
);

  localparam int TW    = gts_pkg::TERM_W;
  localparam int MW    = TW - 1;
  localparam int SumW  = $clog2(MAX_TERMS) + TW;
  localparam int CntW  = $clog2(gts_pkg::DIV_STEPS);
  localparam int SqW   = gts_pkg::SQ_W;
  localparam int TailW = gts_pkg::TAIL_W;
  localparam int TotW  = gts_pkg::TOTAL_W;
  localparam int BW    = gts_pkg::BOUND_W;
  localparam int PrW   = MW + BW;
  localparam logic signed [SumW:0] SumHi =
    (SumW+1)'((longint'(MAX_TERMS) <<< 31) - 64'sd1);
  localparam logic signed [SumW:0] SumLo =
    (SumW+1)'(-(longint'(MAX_TERMS) <<< 31));

  // latched request
  logic signed [TW-1:0]   term_reg;
  logic                   last_reg;
  logic [BW-1:0]          held_bound;
  // series state
  logic                   series_open;
  logic signed [TW-1:0]   newer_term;
  logic                   pair_ok;
  logic signed [SumW-1:0] running_sum;
  logic signed [SumW-1:0] sum_at_cut;
  logic [MW-1:0]          cut_term;
  logic [MW-1:0]          cut_previous;
  logic                   cut_found;
  // divider
  logic [SqW-1:0]         div_n;
  logic [MW-1:0]          div_r;
  logic [MW-1:0]          div_d;
  logic [CntW-1:0]        div_cnt;

  logic                   term_pos, newer_pos, link_ok, cut_now;
  logic [PrW-1:0]         bound_prod;
  logic signed [SumW:0]   sum_wide, sum_sat;
  logic [SqW-1:0]         square;
  logic [MW:0]            rem_shift;
  logic [MW+1:0]          rem_diff;
  logic [TailW-1:0]       tail_sat;
  logic signed [TotW:0]   total_wide;
  logic signed [TotW-1:0] total_sat;
  logic signed [SumW-1:0] base_sum;

  // ratio test: t * 2^16 <= bound * newer, both terms positive
  assign term_pos   = !term_reg[TW-1] && (|term_reg[MW-1:0]);
  assign newer_pos  = !newer_term[TW-1] && (|newer_term[MW-1:0]);
  assign bound_prod = PrW'(held_bound) * PrW'(newer_term[MW-1:0]);
  assign link_ok    = term_pos && newer_pos && ({term_reg[MW-1:0], {BW{1'b0}}} <= bound_prod);
  assign cut_now    = pair_ok && link_ok;

  assign sum_wide = $signed({running_sum[SumW-1], running_sum})
                  + $signed({{(SumW+1-TW){term_reg[TW-1]}}, term_reg});

  always_comb begin
    if (sum_wide > SumHi) begin
      sum_sat = SumHi;
    end else if (sum_wide < SumLo) begin
      sum_sat = SumLo;
    end else begin
      sum_sat = sum_wide;
    end
  end

  assign square    = SqW'(cut_term) * SqW'(cut_term);
  assign rem_shift = {div_r, div_n[SqW-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      series_open <= 1'b0;
      pair_ok     <= 1'b0;
      cut_found   <= 1'b0;
      running_sum <= '0;
      newer_term  <= '0;
    end else if (cmd.step) begin
      series_open <= 1'b1;
      pair_ok     <= link_ok;
      newer_term  <= term_reg;
      running_sum <= sum_sat[SumW-1:0];
      if (cut_now) begin
        cut_found <= 1'b1;
      end
    end else if (cmd.finish) begin
      series_open <= 1'b0;
      pair_ok     <= 1'b0;
      cut_found   <= 1'b0;
      running_sum <= '0;
      newer_term  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      term_reg <= item.term;
      last_reg <= item.last_term;
      if (!series_open) begin
        held_bound <= item.ratio_bound;
      end
    end
    if (cmd.step && cut_now) begin
      cut_term     <= term_reg[MW-1:0];
      cut_previous <= newer_term[MW-1:0];
      sum_at_cut   <= sum_sat[SumW-1:0];
    end
  end

  // restoring division of s*s by p-s, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      div_n   <= square;
      div_r   <= '0;
      div_d   <= cut_previous - cut_term;
      div_cnt <= '0;
    end else if (cmd.divide) begin
      div_cnt <= div_cnt + 1'b1;
      div_n   <= {div_n[SqW-2:0], ~rem_diff[MW+1]};
      div_r   <= rem_diff[MW+1] ? rem_shift[MW-1:0] : rem_diff[MW-1:0];
    end
  end

  always_comb begin
    if (!cut_found) begin
      tail_sat = '0;
    end else if (|div_n[SqW-1:TailW]) begin
      tail_sat = '1;
    end else begin
      tail_sat = div_n[TailW-1:0];
    end
  end

  assign base_sum   = cut_found ? sum_at_cut : running_sum;
  assign total_wide = $signed({{(TotW+1-SumW){base_sum[SumW-1]}}, base_sum})
                    + $signed({{(TotW+1-TailW){1'b0}}, tail_sat});

  always_comb begin
    if (total_wide[TotW] != total_wide[TotW-1]) begin
      total_sat = total_wide[TotW] ? {1'b1, {(TotW-1){1'b0}}} : {1'b0, {(TotW-1){1'b1}}};
    end else begin
      total_sat = total_wide[TotW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.total      <= total_sat;
      result.tail       <= tail_sat;
      result.tail_valid <= cut_found;
    end
  end

  assign status.last_term = last_reg;
  assign status.cut_found = cut_found;
  assign status.div_last  = (div_cnt == CntW'(gts_pkg::DIV_STEPS - 1));

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the geometric tail series sum
// Feeds series of signed terms through the request channel, predicts each
// end-of-series total, tail and flag in a local model, and checks every
// result in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  // field widths and sizing taken from the package
  localparam int TERM_W    = gts_pkg::TERM_W;
  localparam int BOUND_W   = gts_pkg::BOUND_W;
  localparam int TAIL_W    = gts_pkg::TAIL_W;
  localparam int TOTAL_W   = gts_pkg::TOTAL_W;
  localparam int MAX_TERMS = gts_pkg::MAX_TERMS_DEFAULT;
  localparam int SUM_W     = $clog2(MAX_TERMS) + TERM_W;

  // run sizing
  localparam int TOTAL_TERMS    = 1250;
  localparam int MAX_LONG_RUNS  = 3;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int REPORT_LIMIT   = 10;

  // saturation limits of the running sum and of the two result fields
  localparam longint SUM_HI   = (longint'(MAX_TERMS) <<< 31) - 1;
  localparam longint SUM_LO   = -(longint'(MAX_TERMS) <<< 31);
  localparam longint TAIL_MAX = (longint'(1) <<< TAIL_W) - 1;
  localparam longint TOTAL_HI = (longint'(1) <<< (TOTAL_W - 1)) - 1;
  localparam longint TOTAL_LO = -(longint'(1) <<< (TOTAL_W - 1));

  // receiver stall behaviour between long hold-offs
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  gts_pkg::gts_item_t   item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  gts_pkg::gts_result_t result;

  geometric_tail_series_sum #(
    .MAX_TERMS(MAX_TERMS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // series model: mirrors the block's state for the series in flight
  // ---------------------------------------------------------------------------
  logic signed [TERM_W-1:0] older_val    = '0;
  logic signed [TERM_W-1:0] newer_val    = '0;
  logic [1:0]               terms_in_run = '0;   // saturates at two
  logic signed [SUM_W-1:0]  run_sum      = '0;
  logic signed [SUM_W-1:0]  sum_at_cut   = '0;
  logic signed [TERM_W-1:0] cut_val      = '0;
  logic signed [TERM_W-1:0] cut_prev_val = '0;
  logic                     have_cut     = 1'b0;
  logic [BOUND_W-1:0]       held_bound   = '0;

  gts_pkg::gts_result_t expected_sums[$];   // one entry per series still to come out
  gts_pkg::gts_item_t   send_q[$];          // requests not yet offered

  int  mismatch_count = 0;
  int  terms_taken    = 0;
  int  idle_cycles    = 0;
  bit  req_taken      = 1'b0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // a/b at or below the held bound, tested as a*65536 <= bound*b
  function automatic bit within_bound(input longint a, input longint b);
    bit [63:0] lhs;
    bit [63:0] rhs;
    lhs = 64'(a) << 16;
    rhs = 64'(held_bound) * 64'(b);
    return lhs <= rhs;
  endfunction

  // fold one accepted request into the series; queue a result on the last term
  task automatic fold_term(input gts_pkg::gts_item_t req);
    longint               t;
    longint               s;
    longint               d;
    longint               tail_est;
    gts_pkg::gts_result_t res;
    t = longint'($signed(req.term));
    if (terms_in_run == 2'd0) held_bound = req.ratio_bound;
    run_sum = SUM_W'(clamp(longint'(run_sum) + t, SUM_LO, SUM_HI));

    // three positive terms in a row, both ratios inside the bound
    if (terms_in_run >= 2'd2 && t > 0 && newer_val > 0 && older_val > 0 &&
        within_bound(t, longint'(newer_val)) &&
        within_bound(longint'(newer_val), longint'(older_val))) begin
      have_cut     = 1'b1;
      cut_val      = req.term;
      cut_prev_val = newer_val;
      sum_at_cut   = run_sum;
    end
    older_val = newer_val;
    newer_val = req.term;
    if (terms_in_run < 2'd2) terms_in_run++;

    if (req.last_term) begin
      res = '0;
      if (have_cut) begin
        s        = longint'(cut_val);
        d        = longint'(cut_prev_val) - s;
        tail_est = (s * s) / d;
        if (tail_est > TAIL_MAX) tail_est = TAIL_MAX;
        res.tail       = tail_est[TAIL_W-1:0];
        res.total      = TOTAL_W'(clamp(longint'(sum_at_cut) + tail_est, TOTAL_LO, TOTAL_HI));
        res.tail_valid = 1'b1;
      end else begin
        res.total = TOTAL_W'(clamp(longint'(run_sum), TOTAL_LO, TOTAL_HI));
      end
      expected_sums.insert(expected_sums.size(), res);

      // series end: everything but the held bound starts over
      older_val    = '0;
      newer_val    = '0;
      terms_in_run = '0;
      run_sum      = '0;
      sum_at_cut   = '0;
      cut_val      = '0;
      cut_prev_val = '0;
      have_cut     = 1'b0;
    end
  endtask

  task automatic queue_term(input longint value, input int unsigned bound, input bit last);
    gts_pkg::gts_item_t req;
    req.term        = value[TERM_W-1:0];
    req.ratio_bound = bound[BOUND_W-1:0];
    req.last_term   = last;
    send_q.insert(send_q.size(), req);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge, plus the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gts_pkg::gts_result_t want;
    bit                   res_taken;
    req_taken = !rst && item_valid && !item_stall;
    res_taken = !rst && result_valid && !result_stall;
    if (req_taken) begin
      fold_term(item);
      terms_taken++;
    end
    if (res_taken) begin
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: total %0d tail %0d flag %0b",
                   result.total, result.tail, result.tail_valid);
      end else begin
        want = expected_sums.pop_front();
        if (result.total !== want.total || result.tail !== want.tail ||
            result.tail_valid !== want.tail_valid) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b (total tail flag)",
                     want.total, want.tail, want.tail_valid,
                     result.total, result.tail, result.tail_valid);
        end
      end
    end

    // nothing moving on either channel for too long means the block hung
    if (req_taken || res_taken || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: requests in bursts of random length with random gaps between
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    // a stalled request holds; otherwise move on to the next one or idle
    if (!rst && (!item_valid || req_taken)) begin
      if (gap_left != 0 || send_q.size() == 0) begin
        item_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        item       <= send_q.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, with two long hold-offs that let the
  // block back up into its request side
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       holds_run = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (holds_run < 2 && terms_taken >= (holds_run == 0 ? 150 : 700)) begin
      holds_run++;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 2) == 0);
        default:  result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    longint      t;
    longint      value;
    int unsigned r;
    int unsigned bound;
    int          len;
    int          long_runs;
    int          pick;

    long_runs = 0;

    // one-term series at both term extremes and both bound extremes
    queue_term(longint'(32'sh7fffffff), 16'hffff, 1'b1);
    queue_term(-longint'(1) <<< 31, 16'h0000, 1'b1);
    // two terms: too short for a cut point
    queue_term(5, 16'h5555, 1'b0);
    queue_term(3, 16'haaaa, 1'b1);
    // exact halving at bound one half: cuts on the third and fourth terms,
    // the later one wins; the bound on later terms is ignored
    queue_term(1000, 16'h8000, 1'b0);
    queue_term(500, 16'hffff, 1'b0);
    queue_term(250, 16'h0000, 1'b0);
    queue_term(125, 16'h1234, 1'b1);
    // bound zero never allows a cut
    queue_term(100, 16'h0000, 1'b0);
    queue_term(50, 16'hffff, 1'b0);
    queue_term(25, 16'hffff, 1'b1);
    // terms near full scale falling off as slowly as the widest bound allows;
    // the total runs past its positive limit
    queue_term(longint'(32'sh7fffffff), 16'hffff, 1'b0);
    queue_term(longint'(32'sh7fffffff), 16'h0000, 1'b0);
    queue_term(longint'(32'sh7fffffff), 16'h0000, 1'b0);
    queue_term(longint'(32'sh7fff7fff), 16'h0000, 1'b0);
    queue_term(longint'(32'sh7ffeffff), 16'h0000, 1'b1);
    // a negative term breaks the run of positives
    queue_term(1000, 16'h8000, 1'b0);
    queue_term(-500, 16'h8000, 1'b0);
    queue_term(250, 16'h8000, 1'b0);
    queue_term(125, 16'h8000, 1'b1);

    // random series, mostly geometric so that cut points are common
    while (send_q.size() < TOTAL_TERMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // falling series with random ratio and a bound on either side of it
        len = $urandom_range(3, 10);
        t   = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(1, 1000))
                                          : longint'($urandom_range(1, 32'h7fffffff));
        r   = $urandom_range(1, 65535);
        case ($urandom_range(0, 3))
          0:       bound = r;
          1:       bound = (r + $urandom_range(0, 200) > 65535) ? 65535
                                                                : r + $urandom_range(0, 200);
          2:       bound = r - 1;
          default: bound = $urandom_range(0, 65535);
        endcase
        for (int k = 0; k < len; k++) begin
          // now and then a noise term in the middle of the run
          if (k != 0 && $urandom_range(0, 7) == 0) value = longint'(int'($urandom));
          else value = t;
          queue_term(value, (k == 0) ? bound : $urandom_range(0, 65535), k == len - 1);
          t = (t * r) >>> 16;
          if (t > 0 && $urandom_range(0, 5) == 0) t += $urandom_range(0, 3);
        end
      end else if (pick < 80) begin
        // arbitrary terms over the whole signed range
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          queue_term(longint'(int'($urandom)), $urandom_range(0, 65535), k == len - 1);
      end else if (pick < 97 || long_runs >= MAX_LONG_RUNS) begin
        // short series
        len = $urandom_range(1, 2);
        for (int k = 0; k < len; k++)
          queue_term(longint'(int'($urandom)), $urandom_range(0, 65535), k == len - 1);
      end else begin
        // longer than the sum was sized for; the first two runs drive it into saturation
        long_runs++;
        len = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 16);
        for (int k = 0; k < len; k++) begin
          case (long_runs)
            1:       value = longint'(32'sh7fffffff);
            2:       value = -longint'(1) <<< 31;
            default: value = longint'(int'($urandom | 32'h4000_0000));
          endcase
          queue_term(value, $urandom_range(0, 65535), k == len - 1);
        end
      end
    end

    // reset held from the start, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every request taken, every result back, then a quiet spell to catch
    // anything extra the block might still put out
    while (send_q.size() != 0 || item_valid) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/gts_pkg.sv
src/gts_ctrl.sv
src/gts_dp.sv
src/geometric_tail_series_sum.sv
test/tb_top.sv
